// ----- src/spi_pkg.sv -----
// ----------------------------------------------------------------------------
// Segment intersection point package
// Widths, constants and the records that travel down the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package spi_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_BITS   = COORD_BITS + FRAC_BITS;
   localparam int TOL_BITS   = 8;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * COORD_BITS + 2;
   localparam int DET_BITS   = 2 * COORD_BITS + 3;
   localparam int PAIR_BITS  = 2 * COORD_BITS + 1;
   localparam int NPROD_BITS = 3 * COORD_BITS + 2;
   localparam int NSUM_BITS  = 3 * COORD_BITS + 3;
   localparam int NUM_BITS   = NSUM_BITS + FRAC_BITS;
   // Quotient magnitudes of 2^QBITS or more always fall outside every span.
   localparam int QBITS      = OUT_BITS + 1;
   localparam int CMP_BITS   = OUT_BITS + 3;

   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_TOLERANCE = 3'd0;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] ax_lo;
      logic signed [COORD_BITS-1:0] ax_hi;
      logic signed [COORD_BITS-1:0] ay_lo;
      logic signed [COORD_BITS-1:0] ay_hi;
      logic signed [COORD_BITS-1:0] bx_lo;
      logic signed [COORD_BITS-1:0] bx_hi;
      logic signed [COORD_BITS-1:0] by_lo;
      logic signed [COORD_BITS-1:0] by_hi;
   } span_type;

   typedef struct packed {
      span_type              span;
      logic                  det_zero;
      logic                  neg_x;
      logic                  neg_y;
      logic                  ovf_x;
      logic                  ovf_y;
      logic [NUM_BITS-1:0]   rem_x;
      logic [NUM_BITS-1:0]   rem_y;
      logic [DET_BITS-1:0]   dmag;
      logic [QBITS-1:0]      q_x;
      logic [QBITS-1:0]      q_y;
   } div_type;

endpackage

`default_nettype wire

// ----- src/segment_intersection_point_core.sv -----
// ----------------------------------------------------------------------------
// Segment intersection point core
// Finds where two integer segments cross, in fixed point, and flags a hit.
// ----------------------------------------------------------------------------
// A transaction is accepted on a clock edge where start is high and busy is
// low. busy is never raised, so a new pair of segments may enter every cycle.
// Each transaction gives exactly one result, shown for one cycle with
// rsp_valid high, after six arithmetic stages, a 25-stage divider that
// resolves one quotient bit per stage for both coordinates at once, and
// the output register. Throughput is one transaction per cycle.
// The receiver cannot stall, so results leave as they are produced.
// The tolerance register sits at byte address 0 of the APB port. The user
// must write it only while no transaction is in flight; the block does not
// enforce this. Reset clears the pipeline valid bits, the result strobe and
// the tolerance register. A miss (parallel lines or a point outside either
// segment's spans) returns rsp_hit low with both coordinates zero.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_intersection_point_core
   import spi_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic signed [COORD_BITS-1:0] req_ax0,
   input  wire logic signed [COORD_BITS-1:0] req_ay0,
   input  wire logic signed [COORD_BITS-1:0] req_ax1,
   input  wire logic signed [COORD_BITS-1:0] req_ay1,
   input  wire logic signed [COORD_BITS-1:0] req_bx0,
   input  wire logic signed [COORD_BITS-1:0] req_by0,
   input  wire logic signed [COORD_BITS-1:0] req_bx1,
   input  wire logic signed [COORD_BITS-1:0] req_by1,
   output logic                              rsp_valid,
   output logic                              rsp_hit,
   output logic signed [OUT_BITS-1:0]        rsp_cross_x,
   output logic signed [OUT_BITS-1:0]        rsp_cross_y,
   input  wire logic                         csr_psel,
   input  wire logic                         csr_penable,
   input  wire logic                         csr_pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0]     csr_paddr,
   input  wire logic [31:0]                  csr_pwdata,
   output logic [31:0]                       csr_prdata,
   output logic                              csr_pready
);

   logic                  arith_valid, div_valid;
   div_type               arith_data, div_data;
   logic [TOL_BITS-1:0]   tol_ff;
   logic                  valid_ff;
   logic                  hit_ff;
   logic signed [OUT_BITS-1:0] cx_ff, cy_ff;

   logic signed [CMP_BITS-1:0] px_in, py_in;
   logic                       hit_in;
   logic signed [OUT_BITS-1:0] cx_in, cy_in;

   assign busy       = 1'b0;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == CSR_TOLERANCE) ? 32'(tol_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_TOLERANCE)) begin
         tol_ff <= csr_pwdata[TOL_BITS-1:0];
      end
   end

   spi_arith u_arith (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .ax0       (req_ax0),
      .ay0       (req_ay0),
      .ax1       (req_ax1),
      .ay1       (req_ay1),
      .bx0       (req_bx0),
      .by0       (req_by0),
      .bx1       (req_bx1),
      .by1       (req_by1),
      .out_valid (arith_valid),
      .out_data  (arith_data)
   );

   spi_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (arith_valid),
      .in_data   (arith_data),
      .out_valid (div_valid),
      .out_data  (div_data)
   );

   function automatic logic in_span(input logic signed [CMP_BITS-1:0] p,
                                    input logic signed [COORD_BITS-1:0] lo,
                                    input logic signed [COORD_BITS-1:0] hi,
                                    input logic [TOL_BITS-1:0] tol);
      logic signed [CMP_BITS-1:0] lo_w;
      logic signed [CMP_BITS-1:0] hi_w;
      logic signed [CMP_BITS-1:0] tol_w;
      tol_w = $signed(CMP_BITS'(tol));
      lo_w  = (CMP_BITS'(lo) <<< FRAC_BITS) - tol_w;
      hi_w  = (CMP_BITS'(hi) <<< FRAC_BITS) + tol_w;
      return (p >= lo_w) && (p <= hi_w);
   endfunction

   function automatic logic signed [OUT_BITS-1:0] sat_out(
         input logic signed [CMP_BITS-1:0] v);
      logic signed [CMP_BITS-1:0] top;
      logic signed [CMP_BITS-1:0] bot;
      top = CMP_BITS'({1'b0, {(OUT_BITS-1){1'b1}}});
      bot = -top - CMP_BITS'(1);
      if (v > top) begin
         return OUT_BITS'(top);
      end else if (v < bot) begin
         return OUT_BITS'(bot);
      end
      return OUT_BITS'(v);
   endfunction

   always_comb begin
      px_in = div_data.neg_x ? -$signed(CMP_BITS'(div_data.q_x))
                             : $signed(CMP_BITS'(div_data.q_x));
      py_in = div_data.neg_y ? -$signed(CMP_BITS'(div_data.q_y))
                             : $signed(CMP_BITS'(div_data.q_y));
      hit_in = !div_data.det_zero && !div_data.ovf_x && !div_data.ovf_y &&
               in_span(px_in, div_data.span.ax_lo, div_data.span.ax_hi, tol_ff) &&
               in_span(px_in, div_data.span.bx_lo, div_data.span.bx_hi, tol_ff) &&
               in_span(py_in, div_data.span.ay_lo, div_data.span.ay_hi, tol_ff) &&
               in_span(py_in, div_data.span.by_lo, div_data.span.by_hi, tol_ff);
      cx_in = hit_in ? sat_out(px_in) : '0;
      cy_in = hit_in ? sat_out(py_in) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      cx_ff  <= cx_in;
      cy_ff  <= cy_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_hit     = hit_ff;
   assign rsp_cross_x = cx_ff;
   assign rsp_cross_y = cy_ff;

endmodule

`default_nettype wire

// ----- src/spi_arith.sv -----
// ----------------------------------------------------------------------------
// Segment intersection arithmetic front end
// Six stages: differences, products, determinant, numerator products,
// numerators, and magnitudes with the quotient range check.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_arith
   import spi_pkg::*;
(
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic signed [COORD_BITS-1:0] ax0,
   input  wire logic signed [COORD_BITS-1:0] ay0,
   input  wire logic signed [COORD_BITS-1:0] ax1,
   input  wire logic signed [COORD_BITS-1:0] ay1,
   input  wire logic signed [COORD_BITS-1:0] bx0,
   input  wire logic signed [COORD_BITS-1:0] by0,
   input  wire logic signed [COORD_BITS-1:0] bx1,
   input  wire logic signed [COORD_BITS-1:0] by1,
   output logic                              out_valid,
   output div_type                           out_data
);

   logic [5:0] valid_ff;

   // Stage A
   logic signed [DIFF_BITS-1:0]  dxa_a_ff, dya_a_ff, dxb_a_ff, dyb_a_ff;
   logic signed [COORD_BITS-1:0] x1_ff, y1_ff, x2_ff, y2_ff, x3_ff, y3_ff, x4_ff, y4_ff;
   span_type                     span_in;
   span_type                     span_a_ff, span_b_ff, span_c_ff, span_d_ff, span_e_ff;

   // Stage B
   logic signed [PROD_BITS-1:0]  md1_ff, md2_ff;
   logic signed [2*COORD_BITS-1:0] ma1_ff, ma2_ff, mb1_ff, mb2_ff;
   logic signed [DIFF_BITS-1:0]  dxa_b_ff, dya_b_ff, dxb_b_ff, dyb_b_ff;

   // Stage C
   logic signed [DET_BITS-1:0]   det_c_ff, det_d_ff, det_e_ff;
   logic signed [PAIR_BITS-1:0]  pa_ff, pb_ff;
   logic signed [DIFF_BITS-1:0]  dxa_c_ff, dya_c_ff, dxb_c_ff, dyb_c_ff;

   // Stage D
   logic signed [NPROD_BITS-1:0] n1_ff, n2_ff, n3_ff, n4_ff;

   // Stage E
   logic signed [NSUM_BITS-1:0]  nx_ff, ny_ff;

   // Stage F
   logic [NSUM_BITS-1:0]         magx_in, magy_in;
   logic [NUM_BITS-1:0]          numx_in, numy_in;
   logic [DET_BITS-1:0]          dmag_in;
   div_type                      data_in, data_ff;

   always_comb begin
      span_in.ax_lo = (ax0 < ax1) ? ax0 : ax1;
      span_in.ax_hi = (ax0 > ax1) ? ax0 : ax1;
      span_in.ay_lo = (ay0 < ay1) ? ay0 : ay1;
      span_in.ay_hi = (ay0 > ay1) ? ay0 : ay1;
      span_in.bx_lo = (bx0 < bx1) ? bx0 : bx1;
      span_in.bx_hi = (bx0 > bx1) ? bx0 : bx1;
      span_in.by_lo = (by0 < by1) ? by0 : by1;
      span_in.by_hi = (by0 > by1) ? by0 : by1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[4:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      // Stage A
      dxa_a_ff  <= DIFF_BITS'(ax0) - DIFF_BITS'(ax1);
      dya_a_ff  <= DIFF_BITS'(ay0) - DIFF_BITS'(ay1);
      dxb_a_ff  <= DIFF_BITS'(bx0) - DIFF_BITS'(bx1);
      dyb_a_ff  <= DIFF_BITS'(by0) - DIFF_BITS'(by1);
      x1_ff     <= ax0;
      y1_ff     <= ay0;
      x2_ff     <= ax1;
      y2_ff     <= ay1;
      x3_ff     <= bx0;
      y3_ff     <= by0;
      x4_ff     <= bx1;
      y4_ff     <= by1;
      span_a_ff <= span_in;

      // Stage B
      md1_ff    <= PROD_BITS'(dxa_a_ff) * PROD_BITS'(dyb_a_ff);
      md2_ff    <= PROD_BITS'(dya_a_ff) * PROD_BITS'(dxb_a_ff);
      ma1_ff    <= (2*COORD_BITS)'(x1_ff) * (2*COORD_BITS)'(y2_ff);
      ma2_ff    <= (2*COORD_BITS)'(y1_ff) * (2*COORD_BITS)'(x2_ff);
      mb1_ff    <= (2*COORD_BITS)'(x3_ff) * (2*COORD_BITS)'(y4_ff);
      mb2_ff    <= (2*COORD_BITS)'(y3_ff) * (2*COORD_BITS)'(x4_ff);
      dxa_b_ff  <= dxa_a_ff;
      dya_b_ff  <= dya_a_ff;
      dxb_b_ff  <= dxb_a_ff;
      dyb_b_ff  <= dyb_a_ff;
      span_b_ff <= span_a_ff;

      // Stage C
      det_c_ff  <= DET_BITS'(md1_ff) - DET_BITS'(md2_ff);
      pa_ff     <= PAIR_BITS'(ma1_ff) - PAIR_BITS'(ma2_ff);
      pb_ff     <= PAIR_BITS'(mb1_ff) - PAIR_BITS'(mb2_ff);
      dxa_c_ff  <= dxa_b_ff;
      dya_c_ff  <= dya_b_ff;
      dxb_c_ff  <= dxb_b_ff;
      dyb_c_ff  <= dyb_b_ff;
      span_c_ff <= span_b_ff;

      // Stage D
      n1_ff     <= NPROD_BITS'(pa_ff) * NPROD_BITS'(dxb_c_ff);
      n2_ff     <= NPROD_BITS'(dxa_c_ff) * NPROD_BITS'(pb_ff);
      n3_ff     <= NPROD_BITS'(pa_ff) * NPROD_BITS'(dyb_c_ff);
      n4_ff     <= NPROD_BITS'(dya_c_ff) * NPROD_BITS'(pb_ff);
      det_d_ff  <= det_c_ff;
      span_d_ff <= span_c_ff;

      // Stage E
      nx_ff     <= NSUM_BITS'(n1_ff) - NSUM_BITS'(n2_ff);
      ny_ff     <= NSUM_BITS'(n3_ff) - NSUM_BITS'(n4_ff);
      det_e_ff  <= det_d_ff;
      span_e_ff <= span_d_ff;

      // Stage F
      data_ff   <= data_in;
   end

   always_comb begin
      magx_in = nx_ff[NSUM_BITS-1] ? NSUM_BITS'(-nx_ff) : NSUM_BITS'(nx_ff);
      magy_in = ny_ff[NSUM_BITS-1] ? NSUM_BITS'(-ny_ff) : NSUM_BITS'(ny_ff);
      dmag_in = det_e_ff[DET_BITS-1] ? DET_BITS'(-det_e_ff) : DET_BITS'(det_e_ff);
      numx_in = NUM_BITS'(magx_in) << FRAC_BITS;
      numy_in = NUM_BITS'(magy_in) << FRAC_BITS;

      data_in.span     = span_e_ff;
      data_in.det_zero = (det_e_ff == '0);
      data_in.neg_x    = nx_ff[NSUM_BITS-1] ^ det_e_ff[DET_BITS-1];
      data_in.neg_y    = ny_ff[NSUM_BITS-1] ^ det_e_ff[DET_BITS-1];
      // The quotient would need more than QBITS magnitude bits.
      data_in.ovf_x    = (NUM_BITS'(numx_in >> QBITS) >= NUM_BITS'(dmag_in));
      data_in.ovf_y    = (NUM_BITS'(numy_in >> QBITS) >= NUM_BITS'(dmag_in));
      data_in.rem_x    = numx_in;
      data_in.rem_y    = numy_in;
      data_in.dmag     = dmag_in;
      data_in.q_x      = '0;
      data_in.q_y      = '0;
   end

   assign out_valid = valid_ff[5];
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ----- src/spi_divider.sv -----
// ----------------------------------------------------------------------------
// Segment intersection pipelined divider
// Restoring division, one quotient bit of both coordinates per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_divider
   import spi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   input  wire div_type in_data,
   output logic         out_valid,
   output div_type      out_data
);

   logic    valid_ff [0:QBITS];
   div_type stage_ff [0:QBITS];

   assign valid_ff[0] = in_valid;
   assign stage_ff[0] = in_data;

   for (genvar k = 0; k < QBITS; k++) begin : g_step
      localparam int BIT = QBITS - 1 - k;
      logic [NUM_BITS-1:0] dsh;
      logic [NUM_BITS:0]   trial_x, trial_y;
      div_type             step_in;

      always_comb begin
         dsh     = NUM_BITS'(stage_ff[k].dmag) << BIT;
         trial_x = {1'b0, stage_ff[k].rem_x} - {1'b0, dsh};
         trial_y = {1'b0, stage_ff[k].rem_y} - {1'b0, dsh};
         step_in = stage_ff[k];
         if (!trial_x[NUM_BITS]) begin
            step_in.rem_x    = trial_x[NUM_BITS-1:0];
            step_in.q_x[BIT] = 1'b1;
         end
         if (!trial_y[NUM_BITS]) begin
            step_in.rem_y    = trial_y[NUM_BITS-1:0];
            step_in.q_y[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else begin
            valid_ff[k+1] <= valid_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[k+1] <= step_in;
      end
   end

   assign out_valid = valid_ff[QBITS];
   assign out_data  = stage_ff[QBITS];

endmodule

`default_nettype wire

// ----- bench/tb_segment_intersection_point_core.sv -----
// ----------------------------------------------------------------------------
// Segment intersection point core testbench
// Drives directed and random segment pairs, predicts each hit and crossing
// point, and compares every result against the prediction in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_segment_intersection_point_core;
   import spi_pkg::*;

   localparam int LATENCY = 32;

   typedef struct {
      logic signed [COORD_BITS-1:0] c[8];
      logic                         chk;
      logic                         hit;
      logic signed [OUT_BITS-1:0]   x;
      logic signed [OUT_BITS-1:0]   y;
   } pair_row_type;

   typedef struct {
      logic                       hit;
      logic signed [OUT_BITS-1:0] x;
      logic signed [OUT_BITS-1:0] y;
   } point_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   wire  busy;
   logic signed [COORD_BITS-1:0] ax0 = '0, ay0 = '0, ax1 = '0, ay1 = '0;
   logic signed [COORD_BITS-1:0] bx0 = '0, by0 = '0, bx1 = '0, by1 = '0;
   wire  rsp_valid, rsp_hit;
   wire  signed [OUT_BITS-1:0] rsp_cross_x, rsp_cross_y;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   wire  [31:0] csr_prdata;
   wire  csr_pready;

   point_type  expected_points[$];
   logic [7:0] tol_model = '0;
   int         errors = 0;

   segment_intersection_point_core dut (
      .clock, .reset, .start, .busy,
      .req_ax0(ax0), .req_ay0(ay0), .req_ax1(ax1), .req_ay1(ay1),
      .req_bx0(bx0), .req_by0(by0), .req_bx1(bx1), .req_by1(by1),
      .rsp_valid, .rsp_hit, .rsp_cross_x, .rsp_cross_y,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #50000000;
      $display("status: fail");
      $finish;
   end

   function automatic logic within_span(longint p, longint e0, longint e1, longint tol);
      longint lo, hi;
      lo = ((e0 < e1) ? e0 : e1) * 256 - tol;
      hi = ((e0 > e1) ? e0 : e1) * 256 + tol;
      return p >= lo && p <= hi;
   endfunction

   function automatic point_type crossing_point(pair_row_type r);
      longint x1, y1, x2, y2, x3, y3, x4, y4, dxa, dya, dxb, dyb, det, pa, pb, px, py;
      longint top;
      point_type p;
      x1 = r.c[0]; y1 = r.c[1]; x2 = r.c[2]; y2 = r.c[3];
      x3 = r.c[4]; y3 = r.c[5]; x4 = r.c[6]; y4 = r.c[7];
      dxa = x1 - x2; dya = y1 - y2; dxb = x3 - x4; dyb = y3 - y4;
      det = dxa * dyb - dya * dxb;
      top = (64'sd1 <<< (OUT_BITS - 1)) - 1;
      p.hit = 1'b0;
      px = 0;
      py = 0;
      if (det != 0) begin
         pa = x1 * y2 - y1 * x2;
         pb = x3 * y4 - y3 * x4;
         // SystemVerilog division of signed values truncates toward zero.
         px = ((pa * dxb - dxa * pb) * 256) / det;
         py = ((pa * dyb - dya * pb) * 256) / det;
         p.hit = within_span(px, x1, x2, tol_model) && within_span(px, x3, x4, tol_model) &&
                 within_span(py, y1, y2, tol_model) && within_span(py, y3, y4, tol_model);
      end
      if (!p.hit) begin
         px = 0;
         py = 0;
      end
      if (px > top) px = top;
      if (px < -top - 1) px = -top - 1;
      if (py > top) py = top;
      if (py < -top - 1) py = -top - 1;
      p.x = px[OUT_BITS-1:0];
      p.y = py[OUT_BITS-1:0];
      return p;
   endfunction

   // Result checker: every strobe must match the oldest prediction.
   always @(posedge clock) begin
      point_type e;
      if (!reset && rsp_valid) begin
         if (expected_points.size() == 0) begin
            $error("unexpected result hit=%0d x=%0d y=%0d", rsp_hit, rsp_cross_x, rsp_cross_y);
            errors++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_hit !== e.hit) begin
               $error("hit expected %0d actual %0d", e.hit, rsp_hit);
               errors++;
            end
            if (rsp_cross_x !== e.x) begin
               $error("cross_x expected %0d actual %0d", e.x, rsp_cross_x);
               errors++;
            end
            if (rsp_cross_y !== e.y) begin
               $error("cross_y expected %0d actual %0d", e.y, rsp_cross_y);
               errors++;
            end
         end
      end
   end

   task automatic write_tolerance(logic [7:0] value);
      @(negedge clock);
      csr_psel = 1'b1; csr_pwrite = 1'b1; csr_paddr = CSR_TOLERANCE;
      csr_pwdata = {24'($urandom_range(0, 16777215)), value};
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tol_model = value;
      @(negedge clock);
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
   endtask

   task automatic drain_results();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Drives one pair at a falling edge; holds until accepted.
   task automatic send_pair(pair_row_type r, logic keep_start);
      point_type p;
      ax0 <= r.c[0]; ay0 <= r.c[1]; ax1 <= r.c[2]; ay1 <= r.c[3];
      bx0 <= r.c[4]; by0 <= r.c[5]; bx1 <= r.c[6]; by1 <= r.c[7];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      p = crossing_point(r);
      if (r.chk && (p.hit !== r.hit || p.x !== r.x || p.y !== r.y)) begin
         $error("typed row differs: hit expected %0d actual %0d", r.hit, p.hit);
         errors++;
      end
      expected_points.push_back(p);
      @(negedge clock);
      if (!keep_start) start <= 1'b0;
   endtask

   function automatic logic signed [COORD_BITS-1:0] rand_coord(int mode);
      case (mode)
         0: return COORD_BITS'($urandom);
         1: return COORD_BITS'($signed($urandom_range(0, 64)) - 32);
         default: return COORD_BITS'($signed($urandom_range(0, 2000)) - 1000);
      endcase
   endfunction

   function automatic pair_row_type random_pair();
      pair_row_type r;
      int m, kind;
      logic signed [COORD_BITS-1:0] cx, cy;
      m = $urandom_range(0, 2);
      kind = $urandom_range(0, 9);
      r.chk = 1'b0; r.hit = 1'b0; r.x = '0; r.y = '0;
      foreach (r.c[i]) r.c[i] = rand_coord(m);
      if (kind < 5) begin
         // Build two segments through a shared point so hits are common.
         cx = COORD_BITS'(rand_coord(m) / 2); cy = COORD_BITS'(rand_coord(m) / 2);
         r.c[2] = COORD_BITS'(2 * cx - r.c[0] / 2 * 2);
         r.c[3] = COORD_BITS'(2 * cy - r.c[1] / 2 * 2);
         r.c[0] = COORD_BITS'(r.c[0] / 2 * 2); r.c[1] = COORD_BITS'(r.c[1] / 2 * 2);
         r.c[4] = COORD_BITS'(r.c[4] / 2 * 2); r.c[5] = COORD_BITS'(r.c[5] / 2 * 2);
         r.c[6] = COORD_BITS'(2 * cx - r.c[4]); r.c[7] = COORD_BITS'(2 * cy - r.c[5]);
      end else if (kind == 5) begin
         r.c[6] = r.c[4] + (r.c[2] - r.c[0]);
         r.c[7] = r.c[5] + (r.c[3] - r.c[1]);
      end
      return r;
   endfunction

   localparam logic signed [15:0] MN = -16'sd32768;
   localparam logic signed [15:0] MX = 16'sd32767;

   pair_row_type directed[$];

   function automatic pair_row_type row(int a, int b, int c, int d, int e, int f, int g,
                                        int h, logic chk, logic hit, int x, int y);
      pair_row_type r;
      r.c[0] = COORD_BITS'(a); r.c[1] = COORD_BITS'(b);
      r.c[2] = COORD_BITS'(c); r.c[3] = COORD_BITS'(d);
      r.c[4] = COORD_BITS'(e); r.c[5] = COORD_BITS'(f);
      r.c[6] = COORD_BITS'(g); r.c[7] = COORD_BITS'(h);
      r.chk = chk; r.hit = hit; r.x = OUT_BITS'(x); r.y = OUT_BITS'(y);
      return r;
   endfunction

   initial begin
      pair_row_type r;
      int n, gap;
      logic [7:0] tol_set[4];
      tol_set = '{8'd255, 8'd1, 8'd0, 8'd128};
      // Right after reset, tolerance is zero.
      directed.push_back(row(0, 0, 10, 10, 0, 10, 10, 0, 1, 1, 1280, 1280));
      directed.push_back(row(0, 0, 10, 0, 0, 1, 10, 1, 1, 0, 0, 0));
      directed.push_back(row(0, 0, 0, 0, 5, 5, 5, 5, 1, 0, 0, 0));
      directed.push_back(row(0, 0, 1, 1, 5, 0, 6, -1, 1, 0, 0, 0));
      directed.push_back(row(0, 0, 3, 0, 1, -1, 2, 2, 0, 0, 0, 0));
      directed.push_back(row(MN, MN, MX, MX, MN, MX, MX, MN, 0, 0, 0, 0));
      directed.push_back(row(MN, MN, MX, MN, MN, MN, MN, MX, 1, 1, -8388608, -8388608));
      directed.push_back(row(MX, MX, MN, MX, MX, MX, MX, MN, 1, 1, 8388352, 8388352));
      directed.push_back(row(MN, 0, MX, 0, 0, MN, 0, MX, 1, 1, 0, 0));
      directed.push_back(row(-1, -1, 1, 1, -1, 1, 1, -1, 1, 1, 0, 0));
      directed.push_back(row(0, 0, 3, 1, 0, 1, 3, 0, 0, 0, 0, 0));
      directed.push_back(row(-16'sh5555, 16'sh5555, -16'sh2aab, 16'sh2aaa,
                             16'sh5555, -16'sh5556, 16'sh2aaa, -16'sh2aab, 0, 0, 0, 0));
      directed.push_back(row(MX, MN, MN, MX, MN, MN, MX, MX, 0, 0, 0, 0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) send_pair(directed[i], i < directed.size() - 1);
      drain_results();

      // Tolerance extremes: a point just past the end of a segment.
      foreach (tol_set[k]) begin
         write_tolerance(tol_set[k]);
         send_pair(row(0, 0, 1, 0, 2, -1, 2, 1, 0, 0, 0, 0), 1'b1);
         send_pair(row(MN, MN, MN, MX, MN, 0, MX, 1, 0, 0, 0, 0), 1'b1);
         send_pair(row(0, 0, 3, 1, 0, 1, 3, 0, 0, 0, 0, 0), 1'b0);
         drain_results();
      end

      n = 0;
      for (int phase = 0; phase < 4; phase++) begin
         write_tolerance(phase == 0 ? 8'd0 : phase == 1 ? 8'd255 : 8'($urandom_range(0, 255)));
         for (int k = 0; k < 200; k++) begin
            r = random_pair();
            // Idle bursts, none in the last part of the run.
            if (phase < 3 && $urandom_range(0, 5) == 0) begin
               gap = $urandom_range(1, 17);
               start <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            if (phase == 1 && k == 100) begin
               start <= 1'b0;
               while (expected_points.size() != 0) @(negedge clock);
            end
            send_pair(r, k < 199);
            n++;
         end
         drain_results();
      end

      if (errors == 0 && expected_points.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/spi_pkg.sv
src/spi_arith.sv
src/spi_divider.sv
src/segment_intersection_point_core.sv
bench/tb_segment_intersection_point_core.sv
